FILE: hw/rtl/rob_pkg.sv
// Reorder buffer shared package: sizes, command and status codes,
// flag bit positions, entry and cell control structs.
// No dependencies.
package rob_pkg;

  localparam int Depth = 32;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  typedef enum logic [3:0] {
    CMD_ALLOC       = 4'd0,
    CMD_WRITE       = 4'd1,
    CMD_STORE_DONE  = 4'd2,
    CMD_FLUSH_AFTER = 4'd3,
    CMD_FLUSH_ALL   = 4'd4,
    CMD_COMMIT      = 4'd5,
    CMD_READ        = 4'd6,
    CMD_FIND        = 4'd7,
    CMD_NTH         = 4'd8,
    CMD_FIRST       = 4'd9,
    CMD_COUNT       = 4'd10
  } rob_cmd_e;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StMiss = 2'd2;

  localparam int FlBusy      = 0;
  localparam int FlReady     = 1;
  localparam int FlFlushed   = 2;
  localparam int FlStore     = 3;
  localparam int FlStoreDone = 4;
  localparam int FlPred      = 5;
  localparam int FlBranch    = 6;
  localparam int FlJump      = 7;

  localparam logic [1:0] KindBranch = 2'd1;
  localparam logic [1:0] KindJump   = 2'd2;
  localparam logic [1:0] KindStore  = 2'd3;

  typedef enum logic [1:0] {
    SCAN_FIND,
    SCAN_NTH,
    SCAN_FIRST,
    SCAN_COUNT
  } rob_scan_e;

  typedef struct packed {
    logic [9:0]  status;
    logic [4:0]  dest;
    logic [7:0]  tag;
    logic [31:0] pc;
    logic [31:0] target;
    logic [31:0] value;
    logic [31:0] history;
  } rob_entry_t;

  typedef struct packed {
    logic clear;
    logic alloc;
    logic wr_res;
    logic st_done;
    logic flush;
    logic free;
    logic inject;
    logic step;
  } rob_cell_ctrl_t;

  typedef struct packed {
    rob_scan_e  mode;
    logic [4:0] nth;
    logic [7:0] tag;
    logic       last;
  } rob_scan_t;

endpackage

FILE: hw/rtl/rob_cell.sv
// One reorder buffer entry plus its stage of the search token chain.
// Depends on rob_pkg.
module rob_cell import rob_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rob_cell_ctrl_t  ctrl_i,
  input  rob_scan_t       scan_i,
  input  rob_entry_t      alloc_i,
  input  logic [31:0]     value_i,
  input  logic            tok_i,
  input  logic [CntW-1:0] cnt_i,
  output rob_entry_t      entry_o,
  output logic            pass_o,
  output logic [CntW-1:0] cnt_o,
  output logic            hit_o,
  output logic            done_o
);

  logic [9:0]      status_q, status_d;
  rob_entry_t      data_q, data_d;
  logic            tok_q, tok_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            valid, hit, done;

  always_comb begin
    status_d = status_q;
    data_d   = data_q;
    if (ctrl_i.clear) begin
      status_d = '0;
      data_d   = '0;
    end else if (ctrl_i.alloc) begin
      status_d = alloc_i.status;
      data_d   = alloc_i;
    end else begin
      if (ctrl_i.wr_res) begin
        status_d[FlReady] = 1'b1;
        data_d.value      = value_i;
      end
      if (ctrl_i.st_done) status_d[FlStoreDone] = 1'b1;
      if (ctrl_i.flush)   status_d[FlFlushed]   = 1'b1;
      if (ctrl_i.free)    status_d[FlBusy]      = 1'b0;
    end
  end

  assign valid = status_q[FlBusy] & ~status_q[FlFlushed];

  always_comb begin
    unique case (scan_i.mode)
      SCAN_FIND:  hit = valid && (data_q.tag == scan_i.tag);
      SCAN_NTH:   hit = valid && (cnt_q == {1'b0, scan_i.nth});
      SCAN_FIRST: hit = valid;
      SCAN_COUNT: hit = 1'b0;
      default:    hit = 1'b0;
    endcase
  end

  assign done   = tok_q & (hit | scan_i.last);
  assign done_o = done;
  assign hit_o  = tok_q & hit;
  assign pass_o = tok_q & ~done;
  assign cnt_o  = cnt_q + CntW'(valid);

  always_comb begin
    tok_d = tok_q;
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      tok_d = 1'b0;
    end else if (ctrl_i.inject) begin
      tok_d = 1'b1;
      cnt_d = '0;
    end else if (ctrl_i.step) begin
      tok_d = tok_i;
      cnt_d = cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      tok_q    <= 1'b0;
    end else begin
      status_q <= status_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    cnt_q  <= cnt_d;
  end

  always_comb begin
    entry_o        = data_q;
    entry_o.status = status_q;
  end

endmodule

FILE: hw/rtl/reorder_buffer.sv
// Reorder buffer top: stream ports, APB capacity register, command
// sequencer and the ring of rob_cell entries. Depends on rob_pkg, rob_cell.
//
//  channel  | dir | handshake                | payload
//  s_axis   | in  | s_axis_tvalid/tready     | tuser=cmd, tdata=operands
//  m_axis   | out | m_axis_tvalid/tready     | tuser=status, tdata=result
//  apb      | in  | psel/penable, pready=1   | capacity at address 0
//
// Direct commands are accepted in S_IDLE, then executed in S_EXEC once the result register is free.
// Find tag, nth valid and valid count pass a token around the cell chain,
// one cell per cycle, over up to capacity cells. First valid: up to occupancy cells.
// Reset empties the ring at once; a capacity write also empties it.
// A held result stalls the execute step and the end of a scan; a request is taken only in S_IDLE.
module reorder_buffer import rob_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: slot[4:0] tag[12:5] dest[17:13] pc[49:18] target[81:50]
  //        value[113:82] kind[115:114] pred_dir[116] pred_bits[118:117]
  //        history[150:119], zero pad
  input  logic [151:0] s_axis_tdata,
  // tuser: cmd[3:0]
  input  logic [3:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: out_slot[4:0] count[10:5] out_dest[15:11] out_tag[23:16]
  //        out_pc[55:24] out_target[87:56] out_value[119:88]
  //        entry_flags[127:120] out_history[159:128] out_pred_bits[161:160], pad
  output logic [167:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN} state_e;

  state_e          state_q, state_d;
  logic [5:0]      capacity_q;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d, pos_q, pos_d;
  logic [CntW-1:0] occ_q, occ_d, steps_q, steps_d, limit_q, limit_d;
  rob_scan_e       mode_q, mode_d;
  logic [3:0]      cmd_q;
  logic [151:0]    in_q;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_user_q, out_user_d;
  logic [167:0]    out_data_q, out_data_d;

  logic [CntW-1:0] cap;
  logic [IdxW-1:0] cap_m1;
  logic            cfg_we, accept, out_free;

  logic [IdxW-1:0] f_slot;
  logic [7:0]      f_tag;
  logic [4:0]      f_dest;
  logic [31:0]     f_pc, f_target, f_value, f_hist;
  logic [1:0]      f_kind, f_predb;
  logic            f_predt;

  rob_cell_ctrl_t  ctrl [Depth];
  rob_entry_t      entries [Depth];
  logic [Depth-1:0] pass_vec, hit_vec, done_vec;
  logic [CntW-1:0] cnt_vec [Depth];
  rob_scan_t       scan;
  rob_entry_t      alloc_e;

  logic [IdxW-1:0] sel_idx, flush_start, start_idx;
  rob_entry_t      sel_e, res_e;
  logic            slot_ok, load, res_sel, inject, step, clear_all, done_any, hit_any;
  logic [1:0]      res_st;
  logic [IdxW-1:0] res_slot;
  logic [CntW-1:0] res_cnt, scan_cnt;
  logic            do_alloc, do_wr, do_sd, do_flush, do_free;

  function automatic logic [IdxW-1:0] inc_wrap(input logic [IdxW-1:0] x,
                                               input logic [CntW-1:0] c);
    logic [CntW-1:0] nx;
    nx = {1'b0, x} + CntW'(1);
    return (nx == c) ? '0 : nx[IdxW-1:0];
  endfunction

  assign cap    = (capacity_q == '0) ? CntW'(1) :
                  (capacity_q > 6'(Depth)) ? CntW'(Depth) : capacity_q[CntW-1:0];
  assign cap_m1 = IdxW'(cap - CntW'(1));

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {26'd0, capacity_q} : 32'd0;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;

  assign f_slot   = in_q[4:0];
  assign f_tag    = in_q[12:5];
  assign f_dest   = in_q[17:13];
  assign f_pc     = in_q[49:18];
  assign f_target = in_q[81:50];
  assign f_value  = in_q[113:82];
  assign f_kind   = in_q[115:114];
  assign f_predt  = in_q[116];
  assign f_predb  = in_q[118:117];
  assign f_hist   = in_q[150:119];

  assign slot_ok = ({1'b0, f_slot} < cap);

  always_comb begin
    alloc_e = '0;
    alloc_e.status[FlBusy]   = 1'b1;
    alloc_e.status[FlBranch] = (f_kind == KindBranch);
    alloc_e.status[FlJump]   = (f_kind == KindJump);
    alloc_e.status[FlStore]  = (f_kind == KindStore);
    alloc_e.status[FlPred]   = f_predt;
    alloc_e.status[9:8]      = f_predb;
    alloc_e.dest    = f_dest;
    alloc_e.tag     = f_tag;
    alloc_e.pc      = f_pc;
    alloc_e.target  = f_target;
    alloc_e.value   = '0;
    alloc_e.history = f_hist;
  end

  assign flush_start = inc_wrap(f_slot, cap);

  always_comb begin
    if (state_q == S_SCAN)                  sel_idx = pos_q;
    else if (cmd_q == 4'(CMD_COMMIT))       sel_idx = head_q;
    else                                    sel_idx = f_slot;
  end
  assign sel_e = entries[sel_idx];

  assign done_any = |done_vec;
  assign hit_any  = |hit_vec;
  always_comb begin
    scan_cnt = '0;
    for (int k = 0; k < Depth; k++) begin
      if (done_vec[k]) scan_cnt = scan_cnt | cnt_vec[k];
    end
  end

  assign scan.mode = mode_q;
  assign scan.nth  = f_slot;
  assign scan.tag  = f_tag;
  assign scan.last = (steps_q == limit_q - CntW'(1));

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    occ_d     = occ_q;
    pos_d     = pos_q;
    steps_d   = steps_q;
    limit_d   = limit_q;
    mode_d    = mode_q;
    load      = 1'b0;
    res_st    = StMiss;
    res_sel   = 1'b0;
    res_slot  = '0;
    res_cnt   = occ_q;
    res_e     = sel_e;
    inject    = 1'b0;
    start_idx = '0;
    step      = 1'b0;
    clear_all = 1'b0;
    do_alloc  = 1'b0;
    do_wr     = 1'b0;
    do_sd     = 1'b0;
    do_flush  = 1'b0;
    do_free   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          load    = 1'b1;
          unique case (rob_cmd_e'(cmd_q))
            CMD_ALLOC: begin
              if (occ_q >= cap) begin
                res_st = StFull;
              end else begin
                do_alloc = 1'b1;
                tail_d   = inc_wrap(tail_q, cap);
                occ_d    = occ_q + CntW'(1);
                res_cnt  = occ_q + CntW'(1);
                res_st   = StOk;
                res_sel  = 1'b1;
                res_slot = tail_q;
                res_e    = alloc_e;
              end
            end
            CMD_WRITE: begin
              if (slot_ok) begin
                do_wr    = 1'b1;
                res_st   = StOk;
                res_sel  = 1'b1;
                res_slot = f_slot;
                res_e.status[FlReady] = 1'b1;
                res_e.value           = f_value;
              end
            end
            CMD_STORE_DONE: begin
              if (slot_ok) begin
                do_sd    = 1'b1;
                res_st   = StOk;
                res_sel  = 1'b1;
                res_slot = f_slot;
                res_e.status[FlStoreDone] = 1'b1;
              end
            end
            CMD_FLUSH_AFTER: begin
              if (slot_ok) begin
                do_flush = 1'b1;
                res_st   = StOk;
                res_sel  = 1'b1;
                res_slot = f_slot;
              end
            end
            CMD_FLUSH_ALL: begin
              clear_all = 1'b1;
              head_d    = '0;
              tail_d    = '0;
              occ_d     = '0;
              res_cnt   = '0;
              res_st    = StOk;
            end
            CMD_COMMIT: begin
              if (occ_q != '0) begin
                do_free  = 1'b1;
                head_d   = inc_wrap(head_q, cap);
                occ_d    = occ_q - CntW'(1);
                res_cnt  = occ_q - CntW'(1);
                res_st   = StOk;
                res_sel  = 1'b1;
                res_slot = head_q;
              end
            end
            CMD_READ: begin
              if (slot_ok) begin
                res_st   = StOk;
                res_sel  = 1'b1;
                res_slot = f_slot;
              end
            end
            CMD_FIND, CMD_NTH, CMD_COUNT: begin
              load      = 1'b0;
              state_d   = S_SCAN;
              inject    = 1'b1;
              start_idx = (cmd_q == 4'(CMD_NTH)) ? head_q : '0;
              pos_d     = start_idx;
              steps_d   = '0;
              limit_d   = cap;
              mode_d    = (cmd_q == 4'(CMD_FIND)) ? SCAN_FIND :
                          (cmd_q == 4'(CMD_NTH))  ? SCAN_NTH  : SCAN_COUNT;
            end
            CMD_FIRST: begin
              // nothing to walk when the ring is empty
              if (occ_q != '0) begin
                load      = 1'b0;
                state_d   = S_SCAN;
                inject    = 1'b1;
                start_idx = head_q;
                pos_d     = head_q;
                steps_d   = '0;
                limit_d   = occ_q;
                mode_d    = SCAN_FIRST;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (!done_any) begin
          step    = 1'b1;
          pos_d   = inc_wrap(pos_q, cap);
          steps_d = steps_q + CntW'(1);
        end else if (out_free) begin
          step    = 1'b1;
          load    = 1'b1;
          state_d = S_IDLE;
          if (mode_q == SCAN_COUNT) begin
            res_st  = StOk;
            res_cnt = scan_cnt;
          end else if (hit_any) begin
            res_st   = StOk;
            res_sel  = 1'b1;
            res_slot = pos_q;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we) begin
      head_d = '0;
      tail_d = '0;
      occ_d  = '0;
    end
  end

  // per-entry controls
  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      ctrl[k].clear   = clear_all | cfg_we;
      ctrl[k].alloc   = do_alloc & (tail_q == IdxW'(k));
      ctrl[k].wr_res  = do_wr & (f_slot == IdxW'(k));
      ctrl[k].st_done = do_sd & (f_slot == IdxW'(k));
      ctrl[k].free    = do_free & (head_q == IdxW'(k));
      ctrl[k].inject  = inject & (start_idx == IdxW'(k));
      ctrl[k].step    = step;
      // ring range from the entry after slot up to, not including, the tail
      if (flush_start <= tail_q)
        ctrl[k].flush = do_flush && (IdxW'(k) >= flush_start) && (IdxW'(k) < tail_q);
      else
        ctrl[k].flush = do_flush && (CntW'(k) < cap) &&
                        ((IdxW'(k) >= flush_start) || (IdxW'(k) < tail_q));
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_user_d  = out_user_q;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_user_d  = res_st;
      if (res_sel)
        out_data_d = {6'd0, res_e.status[9:8], res_e.history, res_e.status[7:0],
                      res_e.value, res_e.target, res_e.pc, res_e.tag, res_e.dest,
                      res_cnt, res_slot};
      else
        out_data_d = {157'd0, res_cnt, 5'd0};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic            tok_in;
    logic [CntW-1:0] cnt_in;
    if (k == 0) begin : g_wrap
      assign tok_in = pass_vec[cap_m1];
      assign cnt_in = cnt_vec[cap_m1];
    end else begin : g_link
      // cells past the ring end never take the token
      assign tok_in = pass_vec[k-1] & (CntW'(k) < cap);
      assign cnt_in = cnt_vec[k-1];
    end
    rob_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[k]),
      .scan_i  (scan),
      .alloc_i (alloc_e),
      .value_i (f_value),
      .tok_i   (tok_in),
      .cnt_i   (cnt_in),
      .entry_o (entries[k]),
      .pass_o  (pass_vec[k]),
      .cnt_o   (cnt_vec[k]),
      .hit_o   (hit_vec[k]),
      .done_o  (done_vec[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      capacity_q  <= 6'(Depth);
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      pos_q       <= '0;
      steps_q     <= '0;
      limit_q     <= '0;
      mode_q      <= SCAN_FIND;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we) capacity_q <= pwdata[5:0];
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      pos_q       <= pos_d;
      steps_q     <= steps_d;
      limit_q     <= limit_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= s_axis_tuser;
      in_q  <= s_axis_tdata;
    end
    out_user_q <= out_user_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: hw/rtl/rob_checker.sv
// Port-level checks on the reorder buffer result stream, bound to the top.
// Depends on the ROB top level.
module rob_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [167:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("undefined status code");

  a_miss_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != 2'd0 |->
      m_axis_tdata[4:0] == 5'd0 && m_axis_tdata[167:11] == '0)
    else $error("entry fields set on a failed request");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10:5] <= 6'd32)
    else $error("count out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind reorder_buffer rob_checker u_rob_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
